FILE: rtl/core/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every clock edge once reset is released
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/core/ttpr_pkg.sv
// ----------------------------------------------------------------------------
// ttpr_pkg
// Types and constants of the transposition table probe/record block.
// ----------------------------------------------------------------------------
package ttpr_pkg;

  localparam int unsigned TABLE_ENTRIES = 65536;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [0:0] {
    CMD_PROBE  = 1'b0,
    CMD_RECORD = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    BOUND_EXACT = 2'd0,
    BOUND_UPPER = 2'd1,
    BOUND_LOWER = 2'd2,
    BOUND_OPEN  = 2'd3
  } bound_e;

  typedef enum logic [1:0] {
    OUT_MISS   = 2'd0,
    OUT_MOVE   = 2'd1,
    OUT_CUTOFF = 2'd2,
    OUT_RECORD = 2'd3
  } outcome_e;

  typedef struct packed {
    logic               cmd;
    logic               black_to_move;
    logic [63:0]        position_key;
    logic [7:0]         search_depth;
    logic signed [15:0] alpha_bound;
    logic signed [15:0] beta_bound;
    logic signed [15:0] entry_score;
    logic [1:0]         bound_kind;
    logic [31:0]        best_move;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         outcome;
    logic signed [15:0] result_score;
    logic [31:0]        result_move;
  } out_beat_t;

  // one table slot
  typedef struct packed {
    logic               valid;
    logic [63:0]        key;
    logic [31:0]        move;
    logic signed [15:0] score;
    logic [1:0]         kind;
    logic [7:0]         depth;
  } entry_t;

  // item waiting for its table read
  typedef struct packed {
    logic               cmd;
    logic [63:0]        key;
    logic [7:0]         depth;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
  } probe_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    idx_t idx;
  } tbl_req_t;

endpackage

FILE: rtl/core/ttpr_table.sv
// ----------------------------------------------------------------------------
// ttpr_table
// Single-port slot memory with registered read and a clearing sweep after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ttpr_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ttpr_pkg::tbl_req_t req_i,
  input  ttpr_pkg::entry_t   wdata_i,
  output ttpr_pkg::entry_t   rdata_o,
  output logic               busy_o
);

  ttpr_pkg::entry_t mem_q [ttpr_pkg::TABLE_ENTRIES];
  ttpr_pkg::entry_t rdata_q;
  ttpr_pkg::idx_t   clr_idx_q, clr_idx_d;
  logic             clr_busy_q, clr_busy_d;

  always_comb begin
    clr_idx_d  = clr_idx_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_idx_d = clr_idx_q + ttpr_pkg::IDX_W'(1);
      if (&clr_idx_q) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q  <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_idx_q  <= clr_idx_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  // sweep drops the valid bit of every slot, the rest is don't care
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_idx_q] <= '0;
    end else if (req_i.wr_en) begin
      mem_q[req_i.idx] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.idx];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_busy_q;

  `ASSERT_CLK(a_no_access_in_clear, clr_busy_q |-> !(req_i.rd_en || req_i.wr_en),
              "table accessed during clearing sweep")
  `ASSERT_CLK(a_clear_runs_full, (clr_busy_q && !(&clr_idx_q)) |=> clr_busy_q,
              "clearing sweep ended early")

endmodule

FILE: rtl/core/ttpr_resolve.sv
// ----------------------------------------------------------------------------
// ttpr_resolve
// Tag compare and cutoff decision on a probe's slot read; records report done.
// ----------------------------------------------------------------------------
module ttpr_resolve (
  input  ttpr_pkg::probe_t    probe_i,
  input  ttpr_pkg::entry_t    slot_i,
  output ttpr_pkg::out_beat_t res_o
);

  logic               hit;
  logic               deep;
  logic               take_cut;
  logic signed [15:0] cut_score;

  assign hit  = slot_i.valid && (slot_i.key == probe_i.key);
  assign deep = slot_i.depth >= probe_i.depth;

  always_comb begin
    take_cut  = 1'b0;
    cut_score = '0;
    case (slot_i.kind)
      ttpr_pkg::BOUND_EXACT: begin
        take_cut  = 1'b1;
        cut_score = slot_i.score;
      end
      ttpr_pkg::BOUND_UPPER: begin
        if (slot_i.score <= probe_i.alpha) begin
          take_cut  = 1'b1;
          cut_score = probe_i.alpha;
        end
      end
      ttpr_pkg::BOUND_LOWER: begin
        if (slot_i.score >= probe_i.beta) begin
          take_cut  = 1'b1;
          cut_score = probe_i.beta;
        end
      end
      default: begin
        take_cut = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_o = '0;
    if (probe_i.cmd == ttpr_pkg::CMD_RECORD) begin
      res_o.outcome = ttpr_pkg::OUT_RECORD;
    end else if (hit) begin
      if (deep && take_cut) begin
        res_o.outcome      = ttpr_pkg::OUT_CUTOFF;
        res_o.result_score = cut_score;
      end else begin
        res_o.outcome     = ttpr_pkg::OUT_MOVE;
        res_o.result_move = slot_i.move;
      end
    end
  end

endmodule

FILE: rtl/core/transposition_table_probe_record_top.sv
// ----------------------------------------------------------------------------
// transposition_table_probe_record_top
// Direct-mapped transposition table: one probe or record per input beat.
// ----------------------------------------------------------------------------
// Usage:
//   in channel : in_valid_i / in_stall_o / in_beat_i, one probe or record per beat
//   out channel: out_valid_o / out_stall_i / out_beat_o, one result per input beat
//   cfg port   : cfg_we_i / cfg_wdata_i write side_key, write while idle
// The effective key is position_key, xored with side_key when black moves;
// its low bits select the slot.
// Path: an accepted beat reads its slot into the table's read register and
// waits in the read stage; its result is registered as that stage advances.
// Throughput: one beat per cycle while in_stall_o is low, set by the single
// table port (one read or one write per beat). A record writes at its accept
// edge, so a following beat to the same slot already reads the new contents.
// Reset: the table runs a clearing sweep over all TABLE_ENTRIES slots (65536)
// with in_stall_o high; config writes are taken during the sweep.
// Receiver stall: the output register holds, one more beat waits in the read
// stage, then in_stall_o rises.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module transposition_table_probe_record_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ttpr_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ttpr_pkg::out_beat_t out_beat_o,
  input  logic                cfg_we_i,
  input  logic [63:0]         cfg_wdata_i
);

  logic [63:0]         side_key_q;
  logic [63:0]         eff_key;
  logic                in_fire;
  logic                s1_adv;
  logic                s1_v_q, s1_v_d;
  ttpr_pkg::probe_t    s1_q, s1_d;
  logic                out_v_q, out_v_d;
  ttpr_pkg::out_beat_t out_q, res;
  logic                out_load;
  logic                clr_busy;
  ttpr_pkg::tbl_req_t  tbl_req;
  ttpr_pkg::entry_t    tbl_wdata;
  ttpr_pkg::entry_t    tbl_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_key_q <= '0;
    end else if (cfg_we_i) begin
      side_key_q <= cfg_wdata_i;
    end
  end

  assign eff_key = in_beat_i.black_to_move ? (in_beat_i.position_key ^ side_key_q)
                                           : in_beat_i.position_key;

  assign s1_adv     = !out_v_q || !out_stall_i;
  assign in_stall_o = clr_busy || (s1_v_q && !s1_adv);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_load   = s1_v_q && s1_adv;

  always_comb begin
    tbl_req.rd_en = in_fire && (in_beat_i.cmd == ttpr_pkg::CMD_PROBE);
    tbl_req.wr_en = in_fire && (in_beat_i.cmd == ttpr_pkg::CMD_RECORD);
    tbl_req.idx   = eff_key[ttpr_pkg::IDX_W-1:0];

    tbl_wdata.valid = 1'b1;
    tbl_wdata.key   = eff_key;
    tbl_wdata.move  = in_beat_i.best_move;
    tbl_wdata.score = in_beat_i.entry_score;
    tbl_wdata.kind  = in_beat_i.bound_kind;
    tbl_wdata.depth = in_beat_i.search_depth;
  end

  ttpr_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (tbl_req),
    .wdata_i (tbl_wdata),
    .rdata_o (tbl_rdata),
    .busy_o  (clr_busy)
  );

  // read stage: item waits here while its slot comes out of the table
  always_comb begin
    s1_d.cmd   = in_beat_i.cmd;
    s1_d.key   = eff_key;
    s1_d.depth = in_beat_i.search_depth;
    s1_d.alpha = in_beat_i.alpha_bound;
    s1_d.beta  = in_beat_i.beta_bound;
    if (in_fire) begin
      s1_v_d = 1'b1;
    end else if (s1_adv) begin
      s1_v_d = 1'b0;
    end else begin
      s1_v_d = s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
  end

  ttpr_resolve u_resolve (
    .probe_i (s1_q),
    .slot_i  (tbl_rdata),
    .res_o   (res)
  );

  assign out_v_d = out_load || (out_v_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_beat_o  = out_q;

  `ASSERT_CLK(a_empty_during_clear, clr_busy |-> (!s1_v_q && !out_v_q),
              "item in flight during clearing sweep")
  `ASSERT_CLK(a_record_outcome,
              (out_load && (s1_q.cmd == ttpr_pkg::CMD_RECORD)) |=>
              (out_q.outcome == ttpr_pkg::OUT_RECORD),
              "record did not report record done")

endmodule

FILE: tb/transposition_table_probe_record_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// transposition_table_probe_record_top_tb
// Self-checking bench for the direct-mapped transposition table. A shadow
// table predicts every probe and record result, and each output beat is
// compared in order against it. A short directed set covers each cutoff
// rule and its edges, and the random sets that follow revisit a small key
// pool with slot collisions under several side keys.
// ----------------------------------------------------------------------------
module transposition_table_probe_record_top_tb;

  localparam int CYCLE_LIMIT      = 400_000;  // clearing sweep covers all 65536 slots
  localparam int MAX_REPORTS      = 10;
  localparam int NUM_PHASES       = 5;
  localparam int RANDOM_PER_PHASE = 110;
  localparam int POOL_SIZE        = 10;
  localparam int SETTLE_CYCLES    = 4;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURST} stall_mode_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  ttpr_pkg::in_beat_t  in_beat_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  ttpr_pkg::out_beat_t out_beat_o;
  logic                cfg_we_i    = 1'b0;
  logic [63:0]         cfg_wdata_i = '0;

  transposition_table_probe_record_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // shadow of the table and the side key
  ttpr_pkg::entry_t tt_shadow [ttpr_pkg::idx_t];
  logic [63:0]      side_mask = '0;
  logic [63:0]      key_pool [POOL_SIZE];

  ttpr_pkg::in_beat_t  pending_beats [$];
  ttpr_pkg::out_beat_t expected_results [$];

  logic in_taken = 1'b0;
  int   cycle_count    = 0;
  int   mismatch_count = 0;
  int   results_seen   = 0;
  int   outcome_seen [4];
  int   settings_used  = 0;

  function automatic ttpr_pkg::out_beat_t predict_lookup(ttpr_pkg::in_beat_t b);
    logic [63:0]         k;
    ttpr_pkg::idx_t      slot;
    ttpr_pkg::entry_t    e;
    ttpr_pkg::out_beat_t r;
    logic signed [15:0]  stored, alpha, beta;
    r = '0;
    k = b.black_to_move ? (b.position_key ^ side_mask) : b.position_key;
    slot = k[ttpr_pkg::IDX_W-1:0];
    if (b.cmd == ttpr_pkg::CMD_RECORD) begin
      e.valid = 1'b1;
      e.key   = k;
      e.move  = b.best_move;
      e.score = b.entry_score;
      e.kind  = b.bound_kind;
      e.depth = b.search_depth;
      tt_shadow[slot] = e;
      r.outcome = ttpr_pkg::OUT_RECORD;
      return r;
    end
    if (!tt_shadow.exists(slot)) return r;
    e = tt_shadow[slot];
    if (e.key != k) return r;
    stored = e.score;
    alpha  = b.alpha_bound;
    beta   = b.beta_bound;
    r.outcome     = ttpr_pkg::OUT_MOVE;
    r.result_move = e.move;
    if (e.depth >= b.search_depth) begin
      if (e.kind == ttpr_pkg::BOUND_EXACT) begin
        r = '0;
        r.outcome = ttpr_pkg::OUT_CUTOFF;
        r.result_score = stored;
      end else if (e.kind == ttpr_pkg::BOUND_UPPER && stored <= alpha) begin
        r = '0;
        r.outcome = ttpr_pkg::OUT_CUTOFF;
        r.result_score = alpha;
      end else if (e.kind == ttpr_pkg::BOUND_LOWER && stored >= beta) begin
        r = '0;
        r.outcome = ttpr_pkg::OUT_CUTOFF;
        r.result_score = beta;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, ttpr_pkg::out_beat_t want,
                                 ttpr_pkg::out_beat_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s: expected outcome %0d score %0d move %h, got %0d %0d %h",
               $time, what, want.outcome, $signed(want.result_score), want.result_move,
               got.outcome, $signed(got.result_score), got.result_move);
  endtask

  // input accept, prediction and output check
  always @(posedge clk_i) begin
    ttpr_pkg::out_beat_t want;
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o)
      expected_results.push_back(predict_lookup(in_beat_i));
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      outcome_seen[out_beat_o.outcome]++;
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", '0, out_beat_o);
      end else begin
        want = expected_results.pop_front();
        if (out_beat_o.outcome !== want.outcome ||
            out_beat_o.result_score !== want.result_score ||
            out_beat_o.result_move !== want.result_move)
          report_mismatch("result mismatch", want, out_beat_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // sender: bursts of beats separated by random gaps
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (gap_left > 0 || pending_beats.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid_i <= 1'b0;
      end else begin
        in_beat_i  <= pending_beats.pop_front();
        in_valid_i <= 1'b1;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // receiver: stall pattern switches to a random mode after each random-length run
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_mode_left = 0;
  int          stall_tick = 0;

  always @(negedge clk_i) begin
    if (stall_mode_left == 0) begin
      stall_mode      = stall_mode_e'($urandom_range(0, 3));
      stall_mode_left = $urandom_range(16, 96);
    end
    stall_mode_left--;
    stall_tick++;
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= ((stall_tick % 12) < 8);
    endcase
  end

  function automatic ttpr_pkg::in_beat_t make_beat(ttpr_pkg::cmd_e c, int btm,
                                                   logic [63:0] k, int d, int a, int bt,
                                                   int s, ttpr_pkg::bound_e kd,
                                                   logic [31:0] mv);
    ttpr_pkg::in_beat_t b;
    b.cmd           = c;
    b.black_to_move = 1'(btm);
    b.position_key  = k;
    b.search_depth  = 8'(d);
    b.alpha_bound   = 16'(a);
    b.beta_bound    = 16'(bt);
    b.entry_score   = 16'(s);
    b.bound_kind    = kd;
    b.best_move     = mv;
    return b;
  endfunction

  // small scores make bound checks land on both sides of the window
  function automatic logic [15:0] pick_score();
    if ($urandom_range(0, 9) < 6) return 16'($urandom_range(0, 16) - 8);
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [7:0] pick_depth();
    if ($urandom_range(0, 9) < 6) return 8'($urandom_range(0, 7));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic ttpr_pkg::in_beat_t random_beat();
    ttpr_pkg::in_beat_t b;
    logic [63:0]        k;
    int unsigned        pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      b.cmd           = 1'($urandom_range(0, 1));
      b.black_to_move = 1'($urandom_range(0, 1));
      b.position_key  = {$urandom, $urandom};
      b.search_depth  = 8'($urandom_range(0, 255));
      b.alpha_bound   = 16'($urandom_range(0, 65535));
      b.beta_bound    = 16'($urandom_range(0, 65535));
      b.entry_score   = 16'($urandom_range(0, 65535));
      b.bound_kind    = 2'($urandom_range(0, 3));
      b.best_move     = $urandom;
      return b;
    end
    // pool key: the position key is chosen so the effective key hits the pool
    k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    b.cmd           = (pick < 55) ? ttpr_pkg::CMD_RECORD : ttpr_pkg::CMD_PROBE;
    b.black_to_move = 1'($urandom_range(0, 1));
    b.position_key  = b.black_to_move ? (k ^ side_mask) : k;
    b.search_depth  = pick_depth();
    b.alpha_bound   = pick_score();
    b.beta_bound    = pick_score();
    b.entry_score   = pick_score();
    b.bound_kind    = 2'($urandom_range(0, 3));
    b.best_move     = $urandom;
    return b;
  endfunction

  // keep about half the pool across phases (all new in the first); some new keys share a slot with an earlier one
  task automatic refresh_pool(bit all_new);
    int j;
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (all_new || $urandom_range(0, 1) == 1) begin
        key_pool[i] = {$urandom, $urandom};
        if (i > 0 && $urandom_range(0, 2) == 0) begin
          j = $urandom_range(0, i - 1);
          key_pool[i][ttpr_pkg::IDX_W-1:0] = key_pool[j][ttpr_pkg::IDX_W-1:0];
        end
      end
    end
  endtask

  task automatic write_side_key(logic [63:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    side_mask = v;
    settings_used++;
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [63:0] phase_keys [NUM_PHASES];
    logic [63:0] k0, k0x, k1, k2, k3;
    logic [63:0] ones;
    ones = '1;
    k0  = 64'h0123_4567_89ab_0010;
    k0x = 64'hfedc_ba98_7654_0010;  // same slot as k0
    k1  = 64'h1111_2222_3333_0020;
    k2  = 64'h4444_5555_6666_0030;
    k3  = 64'h7777_8888_9999_0040;
    phase_keys[0] = ones;
    phase_keys[1] = {$urandom, $urandom};
    phase_keys[2] = 64'd0;
    phase_keys[3] = {$urandom, $urandom};
    phase_keys[4] = 64'h8000_0000_0000_ffff;
    for (int i = 0; i < 4; i++) outcome_seen[i] = 0;

    @(posedge rst_ni);
    write_side_key(64'd0);

    // directed: each cutoff rule at its edge, shallow depth, open bound,
    // slot collision, and the field extremes
    pending_beats.push_back(make_beat(ttpr_pkg::CMD_PROBE, 0, k0, 0, 0, 0, 0,
                                      ttpr_pkg::BOUND_EXACT, 0));
    pending_beats.push_back(make_beat(ttpr_pkg::CMD_RECORD, 0, k0, 5, 0, 0, 100,
                                      ttpr_pkg::BOUND_EXACT, 32'ha0a0_0001));
    pending_beats.push_back(make_beat(ttpr_pkg::CMD_PROBE, 0, k0, 5, 0, 0, 0,
                                      ttpr_pkg::BOUND_EXACT, 0));
    pending_beats.push_back(make_beat(ttpr_pkg::CMD_PROBE, 0, k0, 6, 0, 0, 0,
                                      ttpr_pkg::BOUND_EXACT, 0));
    pending_beats.push_back(make_beat(ttpr_pkg::CMD_RECORD, 0, k1, 255, 0, 0, -50,
                                      ttpr_pkg::BOUND_UPPER, 32'hb0b0_0002));
    pending_beats.push_back(make_beat(ttpr_pkg::CMD_PROBE, 0, k1, 255, -50, 0, 0,
                                      ttpr_pkg::BOUND_EXACT, 0));
    pending_beats.push_back(make_beat(ttpr_pkg::CMD_PROBE, 0, k1, 0, -51, 0, 0,
                                      ttpr_pkg::BOUND_EXACT, 0));
    pending_beats.push_back(make_beat(ttpr_pkg::CMD_PROBE, 0, k1, 0, 32767, 0, 0,
                                      ttpr_pkg::BOUND_EXACT, 0));
    pending_beats.push_back(make_beat(ttpr_pkg::CMD_RECORD, 0, k2, 3, 0, 0, 40,
                                      ttpr_pkg::BOUND_LOWER, 32'hc0c0_0003));
    pending_beats.push_back(make_beat(ttpr_pkg::CMD_PROBE, 0, k2, 3, 0, 40, 0,
                                      ttpr_pkg::BOUND_EXACT, 0));
    pending_beats.push_back(make_beat(ttpr_pkg::CMD_PROBE, 0, k2, 0, 0, 41, 0,
                                      ttpr_pkg::BOUND_EXACT, 0));
    pending_beats.push_back(make_beat(ttpr_pkg::CMD_PROBE, 0, k2, 0, 0, -32768, 0,
                                      ttpr_pkg::BOUND_EXACT, 0));
    pending_beats.push_back(make_beat(ttpr_pkg::CMD_RECORD, 0, k3, 255, 0, 0, 0,
                                      ttpr_pkg::BOUND_OPEN, 32'hd0d0_0004));
    pending_beats.push_back(make_beat(ttpr_pkg::CMD_PROBE, 0, k3, 0, -32768, 32767, 0,
                                      ttpr_pkg::BOUND_EXACT, 0));
    pending_beats.push_back(make_beat(ttpr_pkg::CMD_PROBE, 0, k0x, 0, 0, 0, 0,
                                      ttpr_pkg::BOUND_EXACT, 0));
    pending_beats.push_back(make_beat(ttpr_pkg::CMD_RECORD, 0, k0x, 1, 0, 0, -7,
                                      ttpr_pkg::BOUND_EXACT, 32'he0e0_0005));
    pending_beats.push_back(make_beat(ttpr_pkg::CMD_PROBE, 0, k0, 0, 0, 0, 0,
                                      ttpr_pkg::BOUND_EXACT, 0));
    pending_beats.push_back(make_beat(ttpr_pkg::CMD_PROBE, 1, k0x, 1, 0, 0, 0,
                                      ttpr_pkg::BOUND_EXACT, 0));
    pending_beats.push_back(make_beat(ttpr_pkg::CMD_RECORD, 1, ones, 255, 32767, 32767,
                                      32767, ttpr_pkg::BOUND_EXACT, 32'hffff_ffff));
    pending_beats.push_back(make_beat(ttpr_pkg::CMD_PROBE, 1, ones, 255, 32767, 32767, 0,
                                      ttpr_pkg::BOUND_EXACT, 0));
    pending_beats.push_back(make_beat(ttpr_pkg::CMD_RECORD, 0, 64'd0, 0, -32768, -32768,
                                      -32768, ttpr_pkg::BOUND_EXACT, 32'd0));
    pending_beats.push_back(make_beat(ttpr_pkg::CMD_PROBE, 0, 64'd0, 0, 0, 0, 0,
                                      ttpr_pkg::BOUND_EXACT, 0));
    pending_beats.push_back(make_beat(ttpr_pkg::CMD_PROBE, 0, 64'd0, 1, 0, 0, 0,
                                      ttpr_pkg::BOUND_EXACT, 0));

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_side_key(phase_keys[p]);
      refresh_pool(p == 0);
      repeat (RANDOM_PER_PHASE) pending_beats.push_back(random_beat());
    end
    wait_drained();

    $display("checked %0d result beats under %0d side-key settings", results_seen,
             settings_used);
    $display("misses %0d, move-only hits %0d, cutoffs %0d, records %0d",
             outcome_seen[ttpr_pkg::OUT_MISS], outcome_seen[ttpr_pkg::OUT_MOVE],
             outcome_seen[ttpr_pkg::OUT_CUTOFF], outcome_seen[ttpr_pkg::OUT_RECORD]);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatch_count,
               expected_results.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
